[rtl/var_residual_and_synthesis_filter_macros.svh]
`ifndef VAR_RESIDUAL_AND_SYNTHESIS_FILTER_MACROS_SVH
`define VAR_RESIDUAL_AND_SYNTHESIS_FILTER_MACROS_SVH
// same-cycle implication
`define VAF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vaf check failed");
// next-cycle implication
`define VAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vaf check failed");
`endif

[rtl/vaf_pkg.sv]
`timescale 1ns / 1ps
package vaf_pkg;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_LAGS     = 16;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int LAG_W        = $clog2(MAX_LAGS);
  localparam int SMP_W        = 16;
  localparam int FRAC_W       = 14;
  localparam int PROD_W       = 2 * SMP_W;
  localparam int ACC_W        = 40;
  localparam int ROW_W        = MAX_CHANNELS * SMP_W;
  localparam int CADDR_W      = LAG_W + CH_W;

  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_SAMPLE  = 2'd1,
    FN_RESTART = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_CHANS = 2'd1,
    CFG_LAGS  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic use_term;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] y;
    logic                    sat;
  } rs_t;

  function automatic rs_t round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0]        b;
    logic signed [ACC_W-FRAC_W-1:0] q;
    rs_t r;
    b = v + ACC_W'(1 << (FRAC_W - 1));
    q = b[ACC_W-1:FRAC_W];
    if (q > $signed((ACC_W-FRAC_W)'(32767))) begin
      r.y = 16'sh7fff;
      r.sat = 1'b1;
    end else if (q < -$signed((ACC_W-FRAC_W)'(32768))) begin
      r.y = 16'sh8000;
      r.sat = 1'b1;
    end else begin
      r.y = q[SMP_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction
endpackage

[rtl/vaf_in_if.sv]
`timescale 1ns / 1ps
interface vaf_in_if import vaf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [3:0]              coef_lag;
  logic [1:0]              coef_row;
  logic [1:0]              coef_col;
  logic signed [15:0]      coef_value;
  logic signed [15:0]      sample_0;
  logic signed [15:0]      sample_1;
  logic signed [15:0]      sample_2;
  logic signed [15:0]      sample_3;
  modport source (output valid, func, coef_lag, coef_row, coef_col, coef_value,
                  sample_0, sample_1, sample_2, sample_3, input ready);
  modport sink   (input valid, func, coef_lag, coef_row, coef_col, coef_value,
                  sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

[rtl/vaf_out_if.sv]
`timescale 1ns / 1ps
interface vaf_out_if import vaf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] out_0;
  logic signed [15:0] out_1;
  logic signed [15:0] out_2;
  logic signed [15:0] out_3;
  logic               saturated;
  modport source (output valid, out_0, out_1, out_2, out_3, saturated, input ready);
  modport sink   (input valid, out_0, out_1, out_2, out_3, saturated, output ready);
endinterface

[rtl/vaf_ram.sv]
`timescale 1ns / 1ps
module vaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/vaf_mac_lane.sv]
`timescale 1ns / 1ps
module vaf_mac_lane import vaf_pkg::*; (
  input  logic                    clk,
  input  lane_ctl_t               ctl,
  input  logic signed [SMP_W-1:0] coef,
  input  logic signed [SMP_W-1:0] hist,
  output logic signed [ACC_W-1:0] acc
);
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      if (ctl.use_term) begin
        prod <= coef * hist;
      end else begin
        prod <= '0;
      end
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end
endmodule

[rtl/var_residual_and_synthesis_filter.sv]
`timescale 1ns / 1ps
// A sample is summed one term per output lane each cycle, walking lag and history
// column through the memories, then goes to the result register once the output is free.
// A priming sample, coefficient load or restart is taken without leaving idle; one item at a time.
// Reset (rst, synchronous) empties the history, head, priming count and output,
// and sets mode 0, four channels, one lag; coefficients stay undefined until loaded.
module var_residual_and_synthesis_filter import vaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  vaf_in_if.sink      din,
  vaf_out_if.source   dout
);
  `include "var_residual_and_synthesis_filter_macros.svh"

  logic                   mode;
  logic [2:0]             channels_in_use;
  logic [4:0]             lags_in_use;
  state_t                 state, state_next;
  logic [LAG_W-1:0]       head;
  logic [LAG_W:0]         primed;
  logic [MAX_LAGS-1:0]    hvalid;
  logic [CADDR_W-1:0]     k;
  logic                   v1, v2, hv1;
  logic [CH_W-1:0]        c1;
  logic [2:0]             nc;
  logic [LAG_W-1:0]       nl_m1;
  logic [LAG_W:0]         nl;
  logic                   accept, start, issue, last, fire;
  logic signed [SMP_W-1:0] xin  [MAX_CHANNELS];
  logic signed [SMP_W-1:0] x    [MAX_CHANNELS];
  logic signed [SMP_W-1:0] ysel [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] satv;
  logic [ROW_W-1:0]       xin_row, x_row, y_row, hrow, hw_data;
  logic                   hw_en;
  logic [LAG_W-1:0]       h_raddr;
  logic signed [SMP_W-1:0] hist_sel;
  lane_ctl_t              ctl;
  logic signed [SMP_W-1:0] coef [MAX_CHANNELS];
  logic signed [ACC_W-1:0] acc  [MAX_CHANNELS];

  always_comb begin
    if (channels_in_use == 3'd0) begin
      nc = 3'd1;
    end else if (channels_in_use > 3'(MAX_CHANNELS)) begin
      nc = 3'(MAX_CHANNELS);
    end else begin
      nc = channels_in_use;
    end
    if (lags_in_use == 5'd0) begin
      nl = (LAG_W+1)'(1);
    end else if (lags_in_use > 5'(MAX_LAGS)) begin
      nl = (LAG_W+1)'(MAX_LAGS);
    end else begin
      nl = (LAG_W+1)'(lags_in_use);
    end
    nl_m1 = LAG_W'(nl - (LAG_W+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      channels_in_use <= 3'd4;
      lags_in_use <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:  mode <= cfg_data[0];
        CFG_CHANS: channels_in_use <= cfg_data[2:0];
        CFG_LAGS:  lags_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  assign xin[0] = din.sample_0;
  assign xin[1] = din.sample_1;
  assign xin[2] = din.sample_2;
  assign xin[3] = din.sample_3;

  assign accept = din.valid && din.ready;
  assign start  = accept && func_t'(din.func) == FN_SAMPLE && primed >= nl;
  assign last   = k == {nl_m1, CH_W'(MAX_CHANNELS - 1)};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_RUN;
      ST_RUN:    if (last) state_next = ST_DRAIN;
      ST_DRAIN:  if (!v1 && !v2) state_next = ST_FINISH;
      ST_FINISH: if (fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    din.ready = state == ST_IDLE;
    issue     = state == ST_RUN;
    fire      = state == ST_FINISH && (!dout.valid || dout.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer counters and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (start) begin
        k <= '0;
      end else if (issue) begin
        k <= k + CADDR_W'(1);
      end
      v1 <= issue;
      v2 <= v1;
    end
    c1 <= k[CH_W-1:0];
    hv1 <= hvalid[h_raddr];
  end

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_x
    assign xin_row[c*SMP_W +: SMP_W] = (3'(c) < nc) ? xin[c] : '0;
    assign x_row[c*SMP_W +: SMP_W]   = x[c];
    assign y_row[c*SMP_W +: SMP_W]   = ysel[c];
    always_ff @(posedge clk) begin
      if (start) begin
        x[c] <= (3'(c) < nc) ? xin[c] : '0;
      end
    end
  end

  // history: one row per lag slot, zero until written since the last restart
  assign hw_en   = (accept && func_t'(din.func) == FN_SAMPLE && primed < nl) || fire;
  assign hw_data = fire ? (mode ? y_row : x_row) : xin_row;
  assign h_raddr = head - LAG_W'(1) - k[CADDR_W-1:CH_W];

  always_ff @(posedge clk) begin
    if (rst || (accept && func_t'(din.func) == FN_RESTART)) begin
      head <= '0;
      primed <= '0;
      hvalid <= '0;
    end else if (hw_en) begin
      head <= head + LAG_W'(1);
      hvalid[head] <= 1'b1;
      if (!fire) begin
        primed <= primed + (LAG_W+1)'(1);
      end
    end
  end

  vaf_ram #(.WIDTH(ROW_W), .DEPTH(MAX_LAGS)) u_hist (
    .clk   (clk),
    .we    (hw_en),
    .waddr (head),
    .wdata (hw_data),
    .raddr (h_raddr),
    .rdata (hrow)
  );

  assign hist_sel = hv1 ? hrow[{c1, 4'b0000} +: SMP_W] : '0;

  always_comb begin
    ctl.clear    = start;
    ctl.mul_en   = v1;
    ctl.acc_en   = v2;
    ctl.use_term = 3'(c1) < nc;
  end

  for (genvar r = 0; r < MAX_CHANNELS; r++) begin : g_lane
    logic signed [ACC_W-1:0] xs, v;
    rs_t rs;

    vaf_ram #(.WIDTH(SMP_W), .DEPTH(MAX_LAGS * MAX_CHANNELS)) u_coef (
      .clk   (clk),
      .we    (accept && func_t'(din.func) == FN_LOAD && din.coef_row == CH_W'(r)),
      .waddr ({din.coef_lag, din.coef_col}),
      .wdata (din.coef_value),
      .raddr (k),
      .rdata (coef[r])
    );

    vaf_mac_lane u_mac (
      .clk  (clk),
      .ctl  (ctl),
      .coef (coef[r]),
      .hist (hist_sel),
      .acc  (acc[r])
    );

    always_comb begin
      xs = {{(ACC_W-SMP_W-FRAC_W){x[r][SMP_W-1]}}, x[r], FRAC_W'(0)};
      v  = mode ? xs + acc[r] : xs - acc[r];
      rs = round_sat(v);
      ysel[r] = (3'(r) < nc) ? rs.y : '0;
      satv[r] = (3'(r) < nc) && rs.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (fire) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
    if (fire) begin
      dout.out_0 <= ysel[0];
      dout.out_1 <= ysel[1];
      dout.out_2 <= ysel[2];
      dout.out_3 <= ysel[3];
      dout.saturated <= |satv;
    end
  end

  `VAF_ASSERT_NEXT(a_fire_shows, fire, dout.valid)
  `VAF_ASSERT_NEXT(a_issue_reads, issue, v1)
  `VAF_ASSERT_NEXT(a_drain_done, state == ST_DRAIN && !v1 && !v2, state == ST_FINISH)
  `VAF_ASSERT_NOW(a_primed_bound, 1'b1, primed <= (LAG_W+1)'(MAX_LAGS))
endmodule

[bench/vaf_checker.sv]
`timescale 1ns / 1ps
module vaf_checker import vaf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  vaf_in_if          din,
  vaf_out_if         dout,
  output int         errors,
  output int         pending,
  output int         accepted,
  output int         checked,
  output int         clipped
);

  typedef struct {
    logic signed [15:0] lane [4];
    logic               sat;
  } filt_result_t;

  filt_result_t expected_q [$];

  logic                mode;
  logic [2:0]          chans;
  logic [4:0]          lags;
  logic signed [15:0]  coef [16][4][4];
  logic signed [15:0]  hist [16][4];
  logic [3:0]          head;
  logic [4:0]          primed;

  filt_result_t        want;
  logic signed [15:0]  got [4];

  task automatic push_vector(input logic signed [15:0] vec [4]);
    for (int c = 0; c < 4; c++) hist[head][c] = vec[c];
    head = head + 4'd1;
  endtask

  task automatic clear_series();
    for (int s = 0; s < 16; s++)
      for (int c = 0; c < 4; c++) hist[s][c] = '0;
    head = '0;
    primed = '0;
  endtask

  task automatic filter_item(input logic [1:0] f, input logic [3:0] lag,
                             input logic [1:0] row, input logic [1:0] col,
                             input logic signed [15:0] cv,
                             input logic signed [15:0] smp [4]);
    int                 nc;
    int                 nl;
    longint             acc;
    longint             v;
    longint             q;
    logic [3:0]         slot;
    logic signed [15:0] x [4];
    filt_result_t       res;
    if (f == FN_LOAD) begin
      coef[lag][row][col] = cv;
    end else if (f == FN_RESTART) begin
      clear_series();
    end else if (f == FN_SAMPLE) begin
      nc = (chans == 0) ? 1 : (chans > 4) ? 4 : chans;
      nl = (lags == 0) ? 1 : (lags > 16) ? 16 : lags;
      for (int c = 0; c < 4; c++) x[c] = (c < nc) ? smp[c] : 16'sd0;
      if (primed < nl) begin
        push_vector(x);
        primed = primed + 5'd1;
      end else begin
        res.sat = 1'b0;
        for (int r = 0; r < 4; r++) begin
          res.lane[r] = '0;
          if (r < nc) begin
            acc = 0;
            for (int j = 1; j <= nl; j++) begin
              slot = head - 4'(j);
              for (int c = 0; c < nc; c++)
                acc += longint'(coef[j-1][r][c]) * longint'(hist[slot][c]);
            end
            v = longint'(x[r]) * 16384;
            v = mode ? v + acc : v - acc;
            q = (v + 8192) >>> 14;
            if (q > 32767) begin
              res.lane[r] = 16'sh7fff;
              res.sat = 1'b1;
            end else if (q < -32768) begin
              res.lane[r] = 16'sh8000;
              res.sat = 1'b1;
            end else begin
              res.lane[r] = q[15:0];
            end
          end
        end
        if (mode) push_vector(res.lane);
        else push_vector(x);
        expected_q.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = 1'b0;
      chans = 3'd4;
      lags = 5'd1;
      clear_series();
      expected_q.delete();
      errors = 0;
      accepted = 0;
      checked = 0;
      clipped = 0;
    end else begin
      if (dout.valid && dout.ready) begin
        checked++;
        got[0] = dout.out_0;
        got[1] = dout.out_1;
        got[2] = dout.out_2;
        got[3] = dout.out_3;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (want.sat) clipped++;
          for (int r = 0; r < 4; r++)
            if (got[r] !== want.lane[r]) begin
              $error("out_%0d expected %0d got %0d", r, want.lane[r], got[r]);
              errors++;
            end
          if (dout.saturated !== want.sat) begin
            $error("saturated expected %0b got %0b", want.sat, dout.saturated);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:  mode = cfg_data[0];
          CFG_CHANS: chans = cfg_data[2:0];
          CFG_LAGS:  lags = cfg_data;
          default: ;
        endcase
      end
      if (din.valid && din.ready) begin
        accepted++;
        filter_item(din.func, din.coef_lag, din.coef_row, din.coef_col, din.coef_value,
                    '{din.sample_0, din.sample_1, din.sample_2, din.sample_3});
      end
    end
    pending = expected_q.size();
  end

endmodule

[bench/tb_var_residual_and_synthesis_filter.sv]
`timescale 1ns / 1ps
module tb_var_residual_and_synthesis_filter;
  import vaf_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int SETTLE = 100;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  int         errors;
  int         pending;
  int         accepted;
  int         checked;
  int         clipped;
  int         cycles;
  int         src_idle;
  int         snk_stall;

  vaf_in_if  din ();
  vaf_out_if dout ();

  var_residual_and_synthesis_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .dout      (dout)
  );

  vaf_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .dout      (dout),
    .errors    (errors),
    .pending   (pending),
    .accepted  (accepted),
    .checked   (checked),
    .clipped   (clipped)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    dout.ready <= ($urandom_range(99) >= snk_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_var_residual_and_synthesis_filter: FAIL");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom);
      default: return 16'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(7))
      6:       return 16'($urandom);
      7:       return 16'sd0;
      default: return 16'($signed($urandom_range(4095)) - 2048);
    endcase
  endfunction

  task automatic send(input func_t f, input logic [3:0] lag, input logic [1:0] row,
                      input logic [1:0] col, input logic signed [15:0] cv,
                      input logic signed [15:0] s0, input logic signed [15:0] s1,
                      input logic signed [15:0] s2, input logic signed [15:0] s3);
    if ($urandom_range(99) < src_idle) begin
      din.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    din.valid      <= 1'b1;
    din.func       <= f;
    din.coef_lag   <= lag;
    din.coef_row   <= row;
    din.coef_col   <= col;
    din.coef_value <= cv;
    din.sample_0   <= s0;
    din.sample_1   <= s1;
    din.sample_2   <= s2;
    din.sample_3   <= s3;
    do @(posedge clk); while (!din.ready);
  endtask

  task automatic load(input logic [3:0] lag, input logic [1:0] row, input logic [1:0] col,
                      input logic signed [15:0] v);
    send(FN_LOAD, lag, row, col, v, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
  endtask

  task automatic sample(input logic signed [15:0] s0, input logic signed [15:0] s1,
                        input logic signed [15:0] s2, input logic signed [15:0] s3);
    send(FN_SAMPLE, 4'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
         s0, s1, s2, s3);
  endtask

  task automatic restart();
    send(FN_RESTART, 4'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    din.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic m, input logic [2:0] ch, input logic [4:0] lg);
    cfg_write(CFG_MODE, {4'd0, m});
    cfg_write(CFG_CHANS, {2'd0, ch});
    cfg_write(CFG_LAGS, lg);
  endtask

  task automatic random_items(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        din.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      k = $urandom_range(99);
      if (k < 72) sample(pick_sample(), pick_sample(), pick_sample(), pick_sample());
      else if (k < 86) load(4'($urandom), 2'($urandom), 2'($urandom), pick_coef());
      else if (k < 91) restart();
      else if (k < 95)
        send(FN_NONE, 4'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else sample(16'sh7fff, 16'sh8000, pick_sample(), 16'($urandom));
    end
    drain();
  endtask

  logic       ph_mode  [9] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
  logic [2:0] ph_chans [9] = '{4, 4, 1, 4, 0, 7, 2, 3, 4};
  logic [4:0] ph_lags  [9] = '{1, 1, 16, 16, 0, 31, 5, 8, 16};
  int         idle_pct [4] = '{0, 74, 0, 32};
  int         stall_pct[4] = '{0, 0, 74, 32};

  initial begin
    cycles = 0;
    src_idle = 0;
    snk_stall = 0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    din.valid = 1'b0;
    din.func = FN_NONE;
    din.coef_lag = '0;
    din.coef_row = '0;
    din.coef_col = '0;
    din.coef_value = '0;
    din.sample_0 = '0;
    din.sample_1 = '0;
    din.sample_2 = '0;
    din.sample_3 = '0;
    dout.ready = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_write(CFG_NONE, 5'd31);
    for (int j = 0; j < 16; j++)
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          load(4'(j), 2'(r), 2'(c), pick_coef());
    drain();

    configure(1'b0, 3'd4, 5'd2);
    load(4'd0, 2'd0, 2'd0, 16'sh7fff);
    load(4'd0, 2'd1, 2'd1, 16'sh8000);
    load(4'd1, 2'd2, 2'd3, 16'sh8000);
    load(4'd15, 2'd3, 2'd3, 16'sh7fff);
    restart();
    sample(16'sh7fff, 16'sh8000, 16'sd0, -16'sd1);
    sample(16'sh8000, 16'sh7fff, 16'sd1, -16'sd1);
    sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(FN_NONE, 4'hf, 2'd3, 2'd3, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    sample(16'sd1, -16'sd1, 16'sd8192, -16'sd8192);
    restart();
    sample(16'sh7fff, 16'sd0, 16'sh8000, 16'sd0);
    sample(16'sd100, -16'sd100, 16'sd0, 16'sd0);
    sample(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    load(4'd0, 2'd0, 2'd0, pick_coef());
    load(4'd0, 2'd1, 2'd1, pick_coef());
    load(4'd1, 2'd2, 2'd3, pick_coef());
    load(4'd15, 2'd3, 2'd3, pick_coef());
    drain();

    for (int p = 0; p < 9; p++) begin
      src_idle  = idle_pct[p % 4];
      snk_stall = stall_pct[p % 4];
      configure(ph_mode[p], ph_chans[p], ph_lags[p]);
      random_items(70);
    end

    $display("Covered %0d transfers in, %0d results checked (%0d clipped),",
             accepted, checked, clipped);
    $display("over 9 register settings in both modes and four idling patterns.");
    if (errors == 0) begin
      $display("tb_var_residual_and_synthesis_filter: PASS");
    end else begin
      $display("tb_var_residual_and_synthesis_filter: FAIL");
    end
    $finish;
  end

endmodule

[var_residual_and_synthesis_filter.f]
+incdir+rtl
rtl/vaf_pkg.sv
rtl/vaf_in_if.sv
rtl/vaf_out_if.sv
rtl/vaf_ram.sv
rtl/vaf_mac_lane.sv
rtl/var_residual_and_synthesis_filter.sv
bench/vaf_checker.sv
bench/tb_var_residual_and_synthesis_filter.sv
